// ----- hw/rtl/brl_pkg.sv -----
// ----------------------------------------------------------------------------
// brl_pkg: shared types and constants for the line rasterizer.
// Holds field widths, request and register codes, the request and pixel
// payload types, and the command and status types between controller and
// datapath.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int COORD_BITS   = 12;
  localparam int DIM_BITS     = 13;
  localparam int CHAN_BITS    = 3;
  localparam int IDX_BITS     = 26;
  localparam int COLOR_BITS   = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = DIM_BITS;
  localparam int CMP_BITS     = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int ROW_BITS     = COORD_BITS + DIM_BITS;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [DIM_BITS-1:0]  WIDTH_RESET   = 13'd512;
  localparam logic [DIM_BITS-1:0]  HEIGHT_RESET  = 13'd512;
  localparam logic [CHAN_BITS-1:0] CHANNEL_RESET = 3'd3;

  typedef struct packed {
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        draw_color;
  } req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         inside_res;
    logic [IDX_BITS-1:0]          byte_index;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         last;
  } pix_t;

  typedef struct packed {
    logic load;
    logic step;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic active;
  } stat_t;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

endpackage

// ----- hw/rtl/brl_ctrl.sv -----
// ----------------------------------------------------------------------------
// brl_ctrl: controller for the line rasterizer.
// Tracks whether the pixel stage is occupied and whether the output register
// holds a pixel, and issues load, step and drain commands to the datapath.
// ----------------------------------------------------------------------------
module brl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_type,
  output logic           req_stall,
  output logic           pix_valid,
  input  logic           pix_stall,
  input  brl_pkg::stat_t stat,
  output brl_pkg::cmd_t  cmd
);

  brl_pkg::state_t state;
  brl_pkg::state_t state_next;
  logic            pix_valid_next;
  logic            drain;
  logic            fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brl_pkg::ST_EMPTY;
      pix_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pix_valid <= pix_valid_next;
    end
  end

  always_comb begin
    drain     = (state == brl_pkg::ST_FULL) && (!pix_valid || !pix_stall);
    req_stall = (state == brl_pkg::ST_FULL) && !drain;
    fire      = req_valid && !req_stall;

    cmd.load  = fire && (req_type == brl_pkg::REQ_LOAD);
    cmd.step  = fire && (req_type == brl_pkg::REQ_STEP) && stat.active;
    cmd.drain = drain;

    state_next = state;
    case (state)
      brl_pkg::ST_EMPTY: begin
        if (cmd.step) state_next = brl_pkg::ST_FULL;
      end
      brl_pkg::ST_FULL: begin
        if (drain && !cmd.step) state_next = brl_pkg::ST_EMPTY;
      end
      default: state_next = brl_pkg::ST_EMPTY;
    endcase

    if (drain) begin
      pix_valid_next = 1'b1;
    end else if (!pix_stall) begin
      pix_valid_next = 1'b0;
    end else begin
      pix_valid_next = pix_valid;
    end
  end

endmodule

// ----- hw/rtl/brl_dpath.sv -----
// ----------------------------------------------------------------------------
// brl_dpath: datapath for the line rasterizer.
// Holds the configuration registers and the line state, performs the error
// update for each step, and computes clipping and the frame buffer byte
// offset over a pixel stage and an output register.
// ----------------------------------------------------------------------------
module brl_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  brl_pkg::cmd_t                        cmd,
  input  brl_pkg::req_t                        req_data,
  input  logic                                 cfg_valid,
  input  logic [brl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [brl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output brl_pkg::stat_t                       stat,
  output brl_pkg::pix_t                        pix_data
);

  localparam int CB = brl_pkg::COORD_BITS;
  localparam int IB = brl_pkg::IDX_BITS;

  logic [brl_pkg::DIM_BITS-1:0]  image_width;
  logic [brl_pkg::DIM_BITS-1:0]  image_height;
  logic [brl_pkg::CHAN_BITS-1:0] channel_count;

  logic                          active;
  logic signed [CB-1:0]          cur_x;
  logic signed [CB-1:0]          cur_y;
  logic signed [CB-1:0]          goal_x;
  logic signed [CB-1:0]          goal_y;
  logic [CB:0]                   abs_dx;
  logic signed [CB+1:0]          neg_abs_dy;
  logic                          dir_x;
  logic                          dir_y;
  logic signed [CB+2:0]          error_term;
  logic [brl_pkg::COLOR_BITS-1:0] line_color;

  logic signed [CB-1:0]          p1_x;
  logic signed [CB-1:0]          p1_y;
  logic                          p1_inside;
  logic                          p1_last;
  logic [brl_pkg::COLOR_BITS-1:0] p1_color;
  logic [IB-1:0]                 p1_row;

  logic signed [CB:0]            dx;
  logic signed [CB:0]            dy;
  logic [CB:0]                   abs_dx_load;
  logic signed [CB+1:0]          nady_load;
  logic signed [CB+2:0]          err_load;
  logic signed [CB+3:0]          e2;
  logic                          move_x;
  logic                          move_y;
  logic signed [CB+2:0]          error_next;
  logic                          at_end;
  logic                          on_image;
  logic [brl_pkg::CMP_BITS-1:0]  ux;
  logic [brl_pkg::CMP_BITS-1:0]  uy;
  logic [brl_pkg::CMP_BITS-1:0]  uw;
  logic [brl_pkg::CMP_BITS-1:0]  uh;
  logic [brl_pkg::ROW_BITS-1:0]  row_full;
  logic [IB-1:0]                 row_sum;
  logic [IB+2:0]                 idx_full;

  assign stat.active = active;

  always_comb begin
    dx          = {req_data.end_x[CB-1], req_data.end_x} -
                  {req_data.start_x[CB-1], req_data.start_x};
    dy          = {req_data.end_y[CB-1], req_data.end_y} -
                  {req_data.start_y[CB-1], req_data.start_y};
    abs_dx_load = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
    nady_load   = dy[CB] ? {dy[CB], dy} : -{dy[CB], dy};
    err_load    = $signed({2'b00, abs_dx_load}) + {nady_load[CB+1], nady_load};

    at_end = (cur_x == goal_x) && (cur_y == goal_y);
    e2     = {error_term, 1'b0};
    move_x = e2 >= $signed({{2{neg_abs_dy[CB+1]}}, neg_abs_dy});
    move_y = e2 <= $signed({3'b000, abs_dx});
    error_next = error_term +
                 (move_x ? {neg_abs_dy[CB+1], neg_abs_dy} : '0) +
                 (move_y ? $signed({2'b00, abs_dx}) : '0);

    ux = brl_pkg::CMP_BITS'($unsigned(cur_x));
    uy = brl_pkg::CMP_BITS'($unsigned(cur_y));
    uw = brl_pkg::CMP_BITS'(image_width);
    uh = brl_pkg::CMP_BITS'(image_height);
    on_image = !cur_x[CB-1] && !cur_y[CB-1] && (ux < uw) && (uy < uh);

    row_full = brl_pkg::ROW_BITS'($unsigned(cur_y)) *
               brl_pkg::ROW_BITS'(image_width);

    row_sum  = p1_row + IB'($unsigned(p1_x));
    idx_full = (IB+3)'(row_sum) * (IB+3)'(channel_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= brl_pkg::WIDTH_RESET;
      image_height  <= brl_pkg::HEIGHT_RESET;
      channel_count <= brl_pkg::CHANNEL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        brl_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        brl_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        brl_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[brl_pkg::CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.load) begin
      active <= 1'b1;
    end else if (cmd.step && at_end) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x      <= req_data.start_x;
      cur_y      <= req_data.start_y;
      goal_x     <= req_data.end_x;
      goal_y     <= req_data.end_y;
      abs_dx     <= abs_dx_load;
      neg_abs_dy <= nady_load;
      dir_x      <= !(req_data.start_x < req_data.end_x);
      dir_y      <= !(req_data.start_y < req_data.end_y);
      error_term <= err_load;
      line_color <= req_data.draw_color;
    end else if (cmd.step && !at_end) begin
      error_term <= error_next;
      if (move_x) cur_x <= dir_x ? cur_x - 1'b1 : cur_x + 1'b1;
      if (move_y) cur_y <= dir_y ? cur_y - 1'b1 : cur_y + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      p1_x      <= cur_x;
      p1_y      <= cur_y;
      p1_inside <= on_image;
      p1_last   <= at_end;
      p1_color  <= line_color;
      p1_row    <= IB'(row_full);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain) begin
      pix_data.pixel_x     <= p1_x;
      pix_data.pixel_y     <= p1_y;
      pix_data.inside_res  <= p1_inside;
      pix_data.byte_index  <= p1_inside ? idx_full[IB-1:0] : '0;
      pix_data.pixel_color <= p1_color;
      pix_data.last        <= p1_last;
    end
  end

endmodule

// ----- hw/rtl/bresenham_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer: integer line rasterizer with clipping and frame
// buffer addressing.
// A load request produces nothing. Each step request while a line is active
// produces one pixel, and the block accepts one request per clock as long as
// the pixel output is not stalled. An accepted step request performs the
// error update and registers the row offset multiply in the pixel stage; the
// column add and the channel scaling then go into the output register when
// the pixel stage drains. The input stalls only while a pixel waits in the
// pixel stage behind a stalled output register.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  brl_pkg::req_t                     req_data,
  output logic                              pix_valid,
  input  logic                              pix_stall,
  output brl_pkg::pix_t                     pix_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [brl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [brl_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  brl_pkg::cmd_t  cmd;
  brl_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  brl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_data.req_type),
    .req_stall (req_stall),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  brl_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_data  (req_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .pix_data  (pix_data)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (pix_valid && pix_stall))
    else $error("Request stalled while the output register could move.");

  a_load_active: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> stat.active)
    else $error("Line not active after a load.");

  a_outside_index: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_data.inside_res) |-> (pix_data.byte_index == '0))
    else $error("Clipped pixel carries a nonzero byte index.");

  a_step_needs_line: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (stat.active && !cmd.load))
    else $error("Step issued with no active line.");

endmodule
